// ===== rtl/core/triangle_face_normal_macros.svh =====
// Assertion macros for the triangle face normal block.
// Included by the top level only; no other dependencies.
`ifndef TRIANGLE_FACE_NORMAL_MACROS_SVH
`define TRIANGLE_FACE_NORMAL_MACROS_SVH

// Implication checked on every rising edge, skipped during reset
`define TFN_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, skipped during reset
`define TFN_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/tfn_pkg.sv =====
// Shared types and constants for the triangle face normal block.
// No dependencies.
package tfn_pkg;

    localparam int MaxVertices = 4096;
    localparam int IdxW = 12;
    localparam int AddrW = $clog2(MaxVertices);
    localparam int PosW = 24;
    localparam int EdgeW = 25;
    localparam int ProdW = 50;
    localparam int CrossW = 51;
    localparam int MagW = 50;
    localparam int NormW = 24;
    localparam int SqW = 50;
    localparam int LenW = 25;
    localparam int NrmOutW = 16;
    localparam int QuoW = 15;
    localparam int DivSteps = 15;
    localparam int SqrtSteps = 25;

    localparam logic KIND_WRITE = 1'b0;
    localparam logic KIND_TRI = 1'b1;

    typedef struct packed {
        logic signed [PosW-1:0] x;
        logic signed [PosW-1:0] y;
        logic signed [PosW-1:0] z;
    } pos_t;

    typedef struct packed {
        logic [NormW-1:0] ax;
        logic [NormW-1:0] ay;
        logic [NormW-1:0] az;
        logic             nx;
        logic             ny;
        logic             nz;
        logic             degen;
    } norm_in_t;

endpackage

// ===== rtl/core/tfn_store.sv =====
// Position store: one write port, three registered read ports.
// Depends on tfn_pkg.
module tfn_store
    import tfn_pkg::*;
(
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [IdxW-1:0]  wr_idx,
    input  pos_t             wr_pos,
    input  logic             rd_en,
    input  logic [IdxW-1:0]  rd_idx_a,
    input  logic [IdxW-1:0]  rd_idx_b,
    input  logic [IdxW-1:0]  rd_idx_c,
    output pos_t             rd_a,
    output pos_t             rd_b,
    output pos_t             rd_c
);

    // three copies of the same content, one per read port
    pos_t mem_a [MaxVertices];
    pos_t mem_b [MaxVertices];
    pos_t mem_c [MaxVertices];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_a[wr_idx[AddrW-1:0]] <= wr_pos;
            mem_b[wr_idx[AddrW-1:0]] <= wr_pos;
            mem_c[wr_idx[AddrW-1:0]] <= wr_pos;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_a <= mem_a[rd_idx_a[AddrW-1:0]];
            rd_b <= mem_b[rd_idx_b[AddrW-1:0]];
            rd_c <= mem_c[rd_idx_c[AddrW-1:0]];
        end
    end

endmodule

// ===== rtl/core/tfn_cross.sv =====
// Edge vectors, cross product and magnitude normalization shift.
// Pipelined, one triangle a cycle while en is high. Depends on tfn_pkg.
module tfn_cross
    import tfn_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     en,
    input  logic     in_valid,
    input  pos_t     v0,
    input  pos_t     v1,
    input  pos_t     v2,
    output logic     out_valid,
    output norm_in_t out_data
);

    logic [3:0] vld_reg;

    // stage 1: edges
    logic signed [EdgeW-1:0] ax_reg, ay_reg, az_reg, bx_reg, by_reg, bz_reg;
    // stage 2: products
    logic signed [ProdW-1:0] p0_reg, p1_reg, p2_reg, p3_reg, p4_reg, p5_reg;
    // stage 3: cross components
    logic signed [CrossW-1:0] cx_reg, cy_reg, cz_reg;
    // stage 4 output
    norm_in_t out_reg;

    logic [MagW-1:0] mx, my, mz, mm;
    logic [MagW-NormW-1:0] hi;
    logic [4:0] sh;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[2:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            ax_reg <= EdgeW'(v1.x) - EdgeW'(v0.x);
            ay_reg <= EdgeW'(v1.y) - EdgeW'(v0.y);
            az_reg <= EdgeW'(v1.z) - EdgeW'(v0.z);
            bx_reg <= EdgeW'(v2.x) - EdgeW'(v0.x);
            by_reg <= EdgeW'(v2.y) - EdgeW'(v0.y);
            bz_reg <= EdgeW'(v2.z) - EdgeW'(v0.z);
            p0_reg <= ay_reg * bz_reg;
            p1_reg <= az_reg * by_reg;
            p2_reg <= az_reg * bx_reg;
            p3_reg <= ax_reg * bz_reg;
            p4_reg <= ax_reg * by_reg;
            p5_reg <= ay_reg * bx_reg;
            cx_reg <= CrossW'(p0_reg) - CrossW'(p1_reg);
            cy_reg <= CrossW'(p2_reg) - CrossW'(p3_reg);
            cz_reg <= CrossW'(p4_reg) - CrossW'(p5_reg);
            out_reg <= {NormW'(mx >> sh), NormW'(my >> sh), NormW'(mz >> sh),
                        cx_reg[CrossW-1], cy_reg[CrossW-1], cz_reg[CrossW-1],
                        (cx_reg == '0) && (cy_reg == '0) && (cz_reg == '0)};
        end
    end

    // magnitudes and the shift that brings the largest under 2^24
    always_comb begin
        mx = cx_reg[CrossW-1] ? MagW'(-cx_reg) : MagW'(cx_reg);
        my = cy_reg[CrossW-1] ? MagW'(-cy_reg) : MagW'(cy_reg);
        mz = cz_reg[CrossW-1] ? MagW'(-cz_reg) : MagW'(cz_reg);
        mm = mx | my | mz;
        hi = mm[MagW-1:NormW];
        sh = '0;
        for (int i = 0; i < MagW - NormW; i++) begin
            if (hi[i]) sh = 5'(i + 1);
        end
    end

    assign out_valid = vld_reg[3];
    assign out_data  = out_reg;

endmodule

// ===== rtl/core/tfn_scale.sv =====
// Sum of squares, pipelined square root and three pipelined dividers.
// One bit per stage, one triangle a cycle while en is high. Depends on tfn_pkg.
module tfn_scale
    import tfn_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             en,
    input  logic             in_valid,
    input  norm_in_t         in_data,
    output logic             out_valid,
    output logic [NrmOutW-1:0] out_x,
    output logic [NrmOutW-1:0] out_y,
    output logic [NrmOutW-1:0] out_z,
    output logic             out_degen
);

    // squares, sum, root load, root steps, divider load, divide steps
    localparam int Depth = 4 + SqrtSteps + DivSteps;
    localparam int NumW = NormW + 15;

    logic [Depth-1:0] vld_reg;
    norm_in_t cur_reg [Depth];

    // squares then sum
    logic [2*NormW-1:0] sqx_reg, sqy_reg, sqz_reg;
    logic [SqW-1:0]     q_reg;

    // square root: restoring, one result bit per stage
    logic [SqW-1:0] srem_reg [SqrtSteps+1];
    logic [LenW-1:0] sroot_reg [SqrtSteps+1];

    // division: numerator a*16384 + L/2, one quotient bit per stage
    logic [NumW-1:0] dn_reg [3][DivSteps+1];
    logic [QuoW-1:0] dq_reg [3][DivSteps+1];
    logic [LenW-1:0] dl_reg [DivSteps+1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[Depth-2:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            cur_reg[0] <= in_data;
            for (int i = 1; i < Depth; i++) cur_reg[i] <= cur_reg[i-1];
            sqx_reg <= in_data.ax * in_data.ax;
            sqy_reg <= in_data.ay * in_data.ay;
            sqz_reg <= in_data.az * in_data.az;
            q_reg <= SqW'(sqx_reg) + SqW'(sqy_reg) + SqW'(sqz_reg);
            srem_reg[0] <= q_reg;
            sroot_reg[0] <= '0;
        end
    end

    // root bit B (k-th from the top): trial = (root << (B+1)) + (1 << 2B), which is
    // (root + 2^B)^2 - root^2; rem holds q - root^2 and the bit is set when trial fits
    for (genvar k = 0; k < SqrtSteps; k++) begin : g_sqrt
        localparam int B = SqrtSteps - 1 - k;
        logic [SqW+1:0] trial;
        always_comb begin
            trial = ({2'b0, SqW'(sroot_reg[k])} << (B + 1)) + ((SqW+2)'(1) << (2 * B));
        end
        always_ff @(posedge aclk) begin
            if (en) begin
                if (trial <= {2'b0, srem_reg[k]}) begin
                    srem_reg[k+1] <= srem_reg[k] - SqW'(trial);
                    sroot_reg[k+1] <= sroot_reg[k] | (LenW'(1) << B);
                end else begin
                    srem_reg[k+1] <= srem_reg[k];
                    sroot_reg[k+1] <= sroot_reg[k];
                end
            end
        end
    end

    // load dividers; zero length only for degenerate items, guarded to 1
    logic [LenW-1:0] len;
    norm_in_t        cs;
    assign cs  = cur_reg[2 + SqrtSteps];
    assign len = (sroot_reg[SqrtSteps] == '0) ? LenW'(1) : sroot_reg[SqrtSteps];

    always_ff @(posedge aclk) begin
        if (en) begin
            dl_reg[0] <= len;
            dn_reg[0][0] <= NumW'({cs.ax, 14'b0}) + NumW'(len >> 1);
            dn_reg[1][0] <= NumW'({cs.ay, 14'b0}) + NumW'(len >> 1);
            dn_reg[2][0] <= NumW'({cs.az, 14'b0}) + NumW'(len >> 1);
            for (int c = 0; c < 3; c++) dq_reg[c][0] <= '0;
        end
    end

    for (genvar k = 0; k < DivSteps; k++) begin : g_div
        localparam int B = DivSteps - 1 - k;
        for (genvar c = 0; c < 3; c++) begin : g_lane
            logic [NumW+QuoW-1:0] dsh;
            always_comb dsh = (NumW+QuoW)'(dl_reg[k]) << B;
            always_ff @(posedge aclk) begin
                if (en) begin
                    if (dsh <= (NumW+QuoW)'(dn_reg[c][k])) begin
                        dn_reg[c][k+1] <= dn_reg[c][k] - NumW'(dsh);
                        dq_reg[c][k+1] <= dq_reg[c][k] | (QuoW'(1) << B);
                    end else begin
                        dn_reg[c][k+1] <= dn_reg[c][k];
                        dq_reg[c][k+1] <= dq_reg[c][k];
                    end
                end
            end
        end
        always_ff @(posedge aclk) begin
            if (en) dl_reg[k+1] <= dl_reg[k];
        end
    end

    // apply signs, force zero for degenerate
    norm_in_t      fin;
    logic [NrmOutW-1:0] mxo, myo, mzo;
    assign fin = cur_reg[Depth-1];
    assign mxo = NrmOutW'(dq_reg[0][DivSteps]);
    assign myo = NrmOutW'(dq_reg[1][DivSteps]);
    assign mzo = NrmOutW'(dq_reg[2][DivSteps]);

    assign out_valid = vld_reg[Depth-1];
    assign out_x = fin.degen ? '0 : (fin.nx ? -mxo : mxo);
    assign out_y = fin.degen ? '0 : (fin.ny ? -myo : myo);
    assign out_z = fin.degen ? '0 : (fin.nz ? -mzo : mzo);
    assign out_degen = fin.degen;

endmodule

// ===== rtl/core/triangle_face_normal.sv =====
// Top level of the triangle face normal block: store, cross product, scaling.
// Depends on tfn_pkg, tfn_store, tfn_cross, tfn_scale and the macros header.
//
// channel  dir  tdata fields (low bit up)                                  tuser
// s_axis   in   vertex_index, pos_x, pos_y, pos_z, corner_a, corner_b, corner_c  kind
// m_axis   out  normal_x, normal_y, normal_z                               degenerate
//
// One word a cycle in and out unless the output stalls. A triangle goes from the accepting
// edge to m_tvalid via the store read on that edge, four cross-product stages, 44 scaling
// stages (square, sum, root load, 25 root, divider load, 15 divide), output register.
// Reset clears only control; the store is undefined until written.
// The whole pipeline holds when the output register is full and not taken.
`include "triangle_face_normal_macros.svh"
module triangle_face_normal
    import tfn_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // vertex_index[11:0], pos_x[35:12], pos_y[59:36], pos_z[83:60],
    // corner_a[95:84], corner_b[107:96], corner_c[119:108]
    input  logic [119:0] s_tdata,
    // kind
    input  logic         s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // normal_x[15:0], normal_y[31:16], normal_z[47:32]
    output logic [47:0]  m_tdata,
    // degenerate
    output logic         m_tuser
);

    logic en, acc, is_tri, rd_vld_reg, xv, sv;
    pos_t a, b, c;
    norm_in_t xd;
    logic [NrmOutW-1:0] nx, ny, nz;
    logic nd;
    logic [47:0] odata_reg;
    logic ouser_reg, ovld_reg;

    // pipeline advances when output slot is free or being drained
    assign en = !ovld_reg || m_tready;
    assign s_tready = en;
    assign acc = s_tvalid && s_tready;
    assign is_tri = acc && (s_tuser == KIND_TRI);

    tfn_store u_store (
        .aclk(aclk),
        .wr_en(acc && (s_tuser == KIND_WRITE)),
        .wr_idx(s_tdata[11:0]),
        .wr_pos({s_tdata[35:12], s_tdata[59:36], s_tdata[83:60]}),
        .rd_en(en),
        .rd_idx_a(s_tdata[95:84]),
        .rd_idx_b(s_tdata[107:96]),
        .rd_idx_c(s_tdata[119:108]),
        .rd_a(a), .rd_b(b), .rd_c(c)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_vld_reg <= 1'b0;
        end else if (en) begin
            rd_vld_reg <= is_tri;
        end
    end

    tfn_cross u_cross (
        .aclk(aclk), .aresetn(aresetn), .en(en), .in_valid(rd_vld_reg),
        .v0(a), .v1(b), .v2(c), .out_valid(xv), .out_data(xd)
    );

    tfn_scale u_scale (
        .aclk(aclk), .aresetn(aresetn), .en(en), .in_valid(xv), .in_data(xd),
        .out_valid(sv), .out_x(nx), .out_y(ny), .out_z(nz), .out_degen(nd)
    );

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ovld_reg <= 1'b0;
        end else if (en) begin
            ovld_reg <= sv;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            odata_reg <= {nz, ny, nx};
            ouser_reg <= nd;
        end
    end

    assign m_tvalid = ovld_reg;
    assign m_tdata = odata_reg;
    assign m_tuser = ouser_reg;

    `TFN_ASSERT_IMPL(a_ready_free, !m_tvalid, s_tready, "ready low with empty output")
    `TFN_ASSERT_IMPL(a_degen_zero, m_tvalid && m_tuser, m_tdata == '0, "degenerate not zero")
    `TFN_ASSERT_NEXT(a_rd_vld, is_tri, rd_vld_reg, "triangle read lost")

endmodule
